>>> hdl/cbsf_pkg.sv
// Shared types and codes for the clipped bitmap shape fill core.
// No dependencies; used by cbsf_row_mask and clipped_bitmap_shape_fill_core.
package cbsf_pkg;

    // Command codes
    localparam logic [2:0] MODE_CLEAR   = 3'd0;
    localparam logic [2:0] MODE_POINT   = 3'd1;
    localparam logic [2:0] MODE_RECT    = 3'd2;
    localparam logic [2:0] MODE_DIAMOND = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    // Configuration register indexes
    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    localparam int unsigned WIDTH_RESET  = 20;
    localparam int unsigned HEIGHT_RESET = 10;

    // Active canvas size, wide enough for the largest array (256)
    typedef logic [8:0] t_size;

    // Signed working coordinate: covers -192..383 without wrapping
    typedef logic signed [10:0] t_coord;

    typedef struct packed {
        logic [2:0]        mode;
        logic signed [7:0] x_pos;
        logic signed [7:0] y_pos;
        logic [6:0]        rect_width;
        logic [6:0]        rect_height;
        logic signed [6:0] diamond_radius;
    } t_cmd;

endpackage

>>> hdl/cbsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cbsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/cbsf_row_mask.sv
// Column mask of one canvas row for a point, rectangle or diamond command.
// Depends on cbsf_pkg.
module cbsf_row_mask #(
    parameter int MAX_WIDTH = 64,
    parameter int ROW_W     = 5
) (
    input  cbsf_pkg::t_cmd       i_cmd,
    input  logic [ROW_W-1:0]     i_row,
    input  cbsf_pkg::t_size      i_act_w,
    output logic [MAX_WIDTH-1:0] o_mask
);

    cbsf_pkg::t_coord y_c;
    cbsf_pkg::t_coord px;
    cbsf_pkg::t_coord py;
    cbsf_pkg::t_coord dy;
    cbsf_pkg::t_coord ady;
    cbsf_pkg::t_coord half;
    cbsf_pkg::t_coord lo;
    cbsf_pkg::t_coord hi;
    logic             row_on;

    assign y_c  = cbsf_pkg::t_coord'(i_row);
    assign px   = cbsf_pkg::t_coord'(i_cmd.x_pos);
    assign py   = cbsf_pkg::t_coord'(i_cmd.y_pos);
    assign dy   = y_c - py;
    assign ady  = (dy < 0) ? -dy : dy;
    // remaining half-span of the diamond on this row
    assign half = cbsf_pkg::t_coord'(i_cmd.diamond_radius) - ady;

    always_comb begin
        unique case (i_cmd.mode)
            cbsf_pkg::MODE_POINT: begin
                row_on = (y_c == py);
                lo     = px;
                hi     = px;
            end
            cbsf_pkg::MODE_RECT: begin
                row_on = (y_c >= py) &&
                         (y_c < py + cbsf_pkg::t_coord'(i_cmd.rect_height));
                lo     = px;
                hi     = px + cbsf_pkg::t_coord'(i_cmd.rect_width)
                         - cbsf_pkg::t_coord'(1);
            end
            cbsf_pkg::MODE_DIAMOND: begin
                row_on = (half >= 0);
                lo     = px - half;
                hi     = px + half;
            end
            default: begin
                row_on = 1'b0;
                lo     = '0;
                hi     = '0;
            end
        endcase
    end

    always_comb begin
        for (int x = 0; x < MAX_WIDTH; x++) begin
            o_mask[x] = row_on &&
                        (cbsf_pkg::t_coord'(x) >= lo) &&
                        (cbsf_pkg::t_coord'(x) <= hi) &&
                        (cbsf_pkg::t_size'(x) < i_act_w);
        end
    end

endmodule

>>> hdl/clipped_bitmap_shape_fill_core.sv
// Top level of the clipped bitmap shape fill core: command sequencer around the row store.
// Depends on cbsf_pkg, cbsf_ram and cbsf_row_mask.
//
//  port group    direction  flow control          beat contents
//  in  (command) to core    i_in_valid/o_in_stall mode, x_pos, y_pos, rect size, radius
//  out (result)  from core  o_out_valid/i_out_stall pixel_value
//  cfg (regs)    to core    i_cfg_valid/o_cfg_ready register index, data
//
// Point, rectangle and diamond walk rows 0..H-1 at one row a cycle through the single
// RAM read port, read-modify-write pipelined, then DRAIN and DONE. Read passes RD,
// RDWAIT and DONE; clear and unused codes go to DONE. One command is in work at a time.
// Reset is synchronous, active low; a per-row valid vector makes the store read blank
// after reset and after clear, so neither needs a sweep.
// A stalled result waits in the output register while the next command is accepted.
module clipped_bitmap_shape_fill_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_mode,
    input  logic signed [7:0] i_x_pos,
    input  logic signed [7:0] i_y_pos,
    input  logic [6:0]        i_rect_width,
    input  logic [6:0]        i_rect_height,
    input  logic signed [6:0] i_diamond_radius,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_pixel_value,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [6:0]        i_cfg_data
);

    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_row, n_row;
    logic                  r_out_vld, n_out_vld;
    logic                  r_wb_vld, n_wb_vld;
    logic [6:0]            r_cfg_w;
    logic [5:0]            r_cfg_h;
    logic [MAX_HEIGHT-1:0] r_row_vld;
    logic                  r_rd_vld;
    logic                  r_out_pix;
    logic                  r_pix;
    cbsf_pkg::t_cmd        r_cmd;
    logic [AW-1:0]         r_wb_row;
    logic [MAX_WIDTH-1:0]  r_wb_mask;

    cbsf_pkg::t_size       act_w;
    cbsf_pkg::t_size       act_h;
    logic                  in_acc;
    logic                  out_take;
    logic                  out_load;
    logic                  last_row;
    logic                  rd_ok;
    logic [MAX_WIDTH-1:0]  row_mask;
    logic [MAX_WIDTH-1:0]  ram_rdata;
    logic [MAX_WIDTH-1:0]  rdata_eff;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic                  ram_we;
    logic [MAX_WIDTH-1:0]  ram_wdata;

    assign act_w = (r_cfg_w > MAX_WIDTH) ? cbsf_pkg::t_size'(MAX_WIDTH)
                                         : cbsf_pkg::t_size'(r_cfg_w);
    assign act_h = (r_cfg_h > MAX_HEIGHT) ? cbsf_pkg::t_size'(MAX_HEIGHT)
                                          : cbsf_pkg::t_size'(r_cfg_h);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_take    = r_out_vld && !i_out_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign o_out_valid = r_out_vld;
    assign o_pixel_value = r_out_pix;
    assign o_cfg_ready = 1'b1;

    assign last_row = (cbsf_pkg::t_size'(r_row) == act_h - cbsf_pkg::t_size'(1));

    assign rd_ok = (r_cmd.x_pos >= 0) &&
                   (cbsf_pkg::t_coord'(r_cmd.x_pos) < cbsf_pkg::t_coord'(act_w)) &&
                   (r_cmd.y_pos >= 0) &&
                   (cbsf_pkg::t_coord'(r_cmd.y_pos) < cbsf_pkg::t_coord'(act_h));

    // rows never written since reset or clear read as blank
    assign rdata_eff = r_rd_vld ? ram_rdata : '0;

    assign ram_re    = (r_state == S_WALK) || (r_state == S_RD);
    assign ram_raddr = (r_state == S_RD) ? r_cmd.y_pos[AW-1:0] : r_row;
    assign ram_we    = r_wb_vld;
    assign ram_wdata = rdata_eff | r_wb_mask;

    cbsf_row_mask #(
        .MAX_WIDTH (MAX_WIDTH),
        .ROW_W     (AW)
    ) u_row_mask (
        .i_cmd   (r_cmd),
        .i_row   (r_row),
        .i_act_w (act_w),
        .o_mask  (row_mask)
    );

    cbsf_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wb_row),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_wb_vld  = 1'b0;
        n_out_vld = r_out_vld;
        if (out_take) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_row = '0;
                    unique case (i_mode) inside
                        cbsf_pkg::MODE_POINT, cbsf_pkg::MODE_RECT,
                        cbsf_pkg::MODE_DIAMOND: begin
                            n_state = (act_h == '0) ? S_DONE : S_WALK;
                        end
                        cbsf_pkg::MODE_READ: n_state = S_RD;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_WALK: begin
                n_wb_vld = 1'b1;
                if (last_row) begin
                    n_state = S_DRAIN;
                end else begin
                    n_row = r_row + AW'(1);
                end
            end
            S_DRAIN:  n_state = S_DONE;
            S_RD:     n_state = S_RDWAIT;
            S_RDWAIT: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
            r_cfg_w   <= 7'(cbsf_pkg::WIDTH_RESET);
            r_cfg_h   <= 6'(cbsf_pkg::HEIGHT_RESET);
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_wb_vld  <= n_wb_vld;
            r_out_vld <= n_out_vld;
            if (in_acc && (i_mode == cbsf_pkg::MODE_CLEAR)) begin
                r_row_vld <= '0;
            end else if (r_wb_vld) begin
                r_row_vld[r_wb_row] <= 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    cbsf_pkg::REG_CANVAS_WIDTH:  r_cfg_w <= i_cfg_data;
                    cbsf_pkg::REG_CANVAS_HEIGHT: r_cfg_h <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd.mode           <= i_mode;
            r_cmd.x_pos          <= i_x_pos;
            r_cmd.y_pos          <= i_y_pos;
            r_cmd.rect_width     <= i_rect_width;
            r_cmd.rect_height    <= i_rect_height;
            r_cmd.diamond_radius <= i_diamond_radius;
            r_pix                <= 1'b0;
        end else if (r_state == S_RDWAIT) begin
            r_pix <= rd_ok && rdata_eff[r_cmd.x_pos[XW-1:0]];
        end
        if (ram_re) begin
            r_rd_vld <= r_row_vld[ram_raddr];
        end
        if (r_state == S_WALK) begin
            r_wb_row  <= r_row;
            r_wb_mask <= row_mask;
        end
        if (out_load) begin
            r_out_pix <= r_pix;
        end
    end

    // a write-back never meets a read of the same row
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (r_wb_row == ram_raddr)))
        else $error("row store read and written at the same row");

    // write-backs only follow a row read issued by the walk
    a_wb_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> ($past(r_state) == S_WALK))
        else $error("write-back without a preceding walk read");

    // clear blanks every row at once
    a_clear_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_mode == cbsf_pkg::MODE_CLEAR)) |=> (r_row_vld == '0))
        else $error("clear left a row marked valid");

    // a new result appears only when a command completes
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_vld) && r_out_vld) |-> ($past(r_state) == S_DONE))
        else $error("result beat raised outside completion");

endmodule
